/* sv/q2e_pkg.sv */
// shared constants, types and the cordic angle table for the pose-to-angles pipeline
package q2e_pkg;

  localparam int SQRT_STEPS   = 29;
  localparam int CORDIC_STEPS = 22;
  // magnitude, normalize, cordic steps, fold/round
  localparam int ATAN_STAGES  = CORDIC_STEPS + 3;
  // products, sums, square, subtract, root, atan2, output
  localparam int LAT          = 4 + SQRT_STEPS + ATAN_STAGES + 1;
  // operand delay from the sum stage to the atan2 inputs
  localparam int DLY          = SQRT_STEPS + 2;

  localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;
  localparam logic signed [25:0] ANG_90  = 26'sd5898240;
  localparam logic signed [25:0] ANG_180 = 26'sd11796480;

  typedef logic signed [33:0] opnd_t;
  typedef logic signed [25:0] ang_t;

  // words that ride alongside the angle datapath
  typedef struct packed {
    logic        ook;
    logic        pok;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } side_t;

  // atan2 operands for the three angles
  typedef struct packed {
    opnd_t s;
    opnd_t yaw_y;
    opnd_t yaw_x;
    opnd_t roll_y;
    opnd_t roll_x;
  } ops_t;

  // atan(2^-i) in 2^-16 degree, rounded to nearest
  function automatic ang_t step_angle(input int i);
    ang_t a;
    case (i)
      0:  a = 26'sd2949120;
      1:  a = 26'sd1740967;
      2:  a = 26'sd919879;
      3:  a = 26'sd466945;
      4:  a = 26'sd234379;
      5:  a = 26'sd117304;
      6:  a = 26'sd58666;
      7:  a = 26'sd29335;
      8:  a = 26'sd14668;
      9:  a = 26'sd7334;
      10: a = 26'sd3667;
      11: a = 26'sd1833;
      12: a = 26'sd917;
      13: a = 26'sd458;
      14: a = 26'sd229;
      15: a = 26'sd115;
      16: a = 26'sd57;
      17: a = 26'sd29;
      18: a = 26'sd14;
      19: a = 26'sd7;
      20: a = 26'sd4;
      21: a = 26'sd2;
      default: a = 26'sd0;
    endcase
    return a;
  endfunction

endpackage

/* sv/quaternion_to_euler_angles_core.sv */
// Head pose to pitch/yaw/roll: a fully pipelined datapath that takes one word per
// cycle while not stalled through 59 register stages (4 product and sum stages, a
// 29-stage square root for the pitch cosine, 25 stages per atan2 cordic unit, one
// output register). The three atan2 units run side by side, and all stages advance
// together whenever the output register is empty or being taken, so in_stall
// follows out_stall only while a result is held.
module quaternion_to_euler_angles_core import q2e_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [31:0] pos_x_in,
  input  logic signed [31:0] pos_y_in,
  input  logic signed [31:0] pos_z_in,
  input  logic               orient_ok_in,
  input  logic               pos_ok_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] pitch_deg,
  output logic signed [15:0] yaw_deg,
  output logic signed [15:0] roll_deg,
  output logic signed [31:0] pos_x_out,
  output logic signed [31:0] pos_y_out,
  output logic signed [31:0] pos_z_out,
  output logic               orient_ok_out,
  output logic               pos_ok_out
);

  logic en;
  logic  vld  [0:LAT-1];
  side_t side [0:LAT-1];

  assign en       = !(vld[LAT-1] && out_stall);
  assign in_stall = vld[LAT-1] && out_stall;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < LAT; k++) vld[k] <= vld[k-1];
    end
  end

  // flags and masked position ride along
  always_ff @(posedge clk) begin
    if (en) begin
      side[0].ook <= orient_ok_in;
      side[0].pok <= pos_ok_in;
      side[0].px  <= pos_ok_in ? pos_x_in : '0;
      side[0].py  <= pos_ok_in ? pos_y_in : '0;
      side[0].pz  <= pos_ok_in ? pos_z_in : '0;
      for (int k = 1; k < LAT; k++) side[k] <= side[k-1];
    end
  end

  // component products, exact in Q2.28
  logic signed [31:0] p_wx, p_zy, p_wy, p_xz, p_xx, p_yy, p_wz, p_xy, p_zz;
  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= quat_w * quat_x;
      p_zy <= quat_z * quat_y;
      p_wy <= quat_w * quat_y;
      p_xz <= quat_x * quat_z;
      p_xx <= quat_x * quat_x;
      p_yy <= quat_y * quat_y;
      p_wz <= quat_w * quat_z;
      p_xy <= quat_x * quat_y;
      p_zz <= quat_z * quat_z;
    end
  end

  // atan2 operands, pitch sine clamped to one
  opnd_t s_raw, s_cl;
  always_comb begin
    s_raw = (34'(p_wx) - 34'(p_zy)) <<< 1;
    if (s_raw > ONE_Q28) begin
      s_cl = ONE_Q28;
    end else if (s_raw < -ONE_Q28) begin
      s_cl = -ONE_Q28;
    end else begin
      s_cl = s_raw;
    end
  end

  ops_t ops [0:DLY];
  always_ff @(posedge clk) begin
    if (en) begin
      ops[0].s      <= s_cl;
      ops[0].yaw_y  <= (34'(p_wy) + 34'(p_xz)) <<< 1;
      ops[0].yaw_x  <= ONE_Q28 - ((34'(p_xx) + 34'(p_yy)) <<< 1);
      ops[0].roll_y <= (34'(p_wz) + 34'(p_xy)) <<< 1;
      ops[0].roll_x <= ONE_Q28 - ((34'(p_xx) + 34'(p_zz)) <<< 1);
      for (int k = 1; k <= DLY; k++) ops[k] <= ops[k-1];
    end
  end

  // cosine radicand: 2^56 - s^2
  logic signed [59:0] ss;
  logic [56:0]        rad;
  always_ff @(posedge clk) begin
    if (en) begin
      ss  <= $signed(ops[0].s[29:0]) * $signed(ops[0].s[29:0]);
      rad <= (57'(1) << 56) - ss[56:0];
    end
  end

  logic [28:0] cosv;
  q2e_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .n    (rad),
    .root (cosv)
  );

  logic signed [15:0] pitch_a, yaw_a, roll_a;

  q2e_atan2 u_pitch (
    .clk   (clk),
    .en    (en),
    .yv    (ops[DLY].s),
    .xv    (opnd_t'({5'b0, cosv})),
    .angle (pitch_a)
  );

  q2e_atan2 u_yaw (
    .clk   (clk),
    .en    (en),
    .yv    (ops[DLY].yaw_y),
    .xv    (ops[DLY].yaw_x),
    .angle (yaw_a)
  );

  q2e_atan2 u_roll (
    .clk   (clk),
    .en    (en),
    .yv    (ops[DLY].roll_y),
    .xv    (ops[DLY].roll_x),
    .angle (roll_a)
  );

  // output register, angles zeroed when orientation is invalid
  always_ff @(posedge clk) begin
    if (en) begin
      pitch_deg <= side[LAT-2].ook ? pitch_a[14:0] : '0;
      yaw_deg   <= side[LAT-2].ook ? yaw_a : '0;
      roll_deg  <= side[LAT-2].ook ? roll_a : '0;
    end
  end

  assign out_valid     = vld[LAT-1];
  assign pos_x_out     = side[LAT-1].px;
  assign pos_y_out     = side[LAT-1].py;
  assign pos_z_out     = side[LAT-1].pz;
  assign orient_ok_out = side[LAT-1].ook;
  assign pos_ok_out    = side[LAT-1].pok;

endmodule

/* sv/q2e_sqrt.sv */
// pipelined restoring integer square root, one result bit per stage
module q2e_sqrt import q2e_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [56:0] n,
  output logic [28:0] root
);

  logic [57:0] rem_q [1:SQRT_STEPS];
  logic [57:0] res_q [1:SQRT_STEPS];

  genvar k;
  generate
    for (k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [57:0] BITV = 58'(1) << (2 * (SQRT_STEPS - 1 - k));
      logic [57:0] rem_in, res_in, trial;
      if (k == 0) begin : g_first
        assign rem_in = {1'b0, n};
        assign res_in = '0;
      end else begin : g_rest
        assign rem_in = rem_q[k];
        assign res_in = res_q[k];
      end
      assign trial = res_in + BITV;
      // one compare and subtract per stage
      always_ff @(posedge clk) begin
        if (en) begin
          if (rem_in >= trial) begin
            rem_q[k+1] <= rem_in - trial;
            res_q[k+1] <= (res_in >> 1) + BITV;
          end else begin
            rem_q[k+1] <= rem_in;
            res_q[k+1] <= res_in >> 1;
          end
        end
      end
    end
  endgenerate

  assign root = res_q[SQRT_STEPS][28:0];

endmodule

/* sv/q2e_atan2.sv */
// pipelined atan2: normalize, vectoring cordic, quadrant fold and rounding
module q2e_atan2 import q2e_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  opnd_t              yv,
  input  opnd_t              xv,
  output logic signed [15:0] angle
);

  // magnitudes and coarse right shift
  logic [32:0] ax, ay, mx;
  logic [29:0] ax_r, ay_r;
  logic [29:0] na, nb;
  logic        zero_a, yneg_a, xneg_a;

  always_comb begin
    ax = xv[33] ? 33'(-xv) : xv[32:0];
    ay = yv[33] ? 33'(-yv) : yv[32:0];
    mx = (ax > ay) ? ax : ay;
    if (mx[32]) begin
      na = 30'(ax >> 3);
      nb = 30'(ay >> 3);
    end else if (mx[31]) begin
      na = 30'(ax >> 2);
      nb = 30'(ay >> 2);
    end else if (mx[30]) begin
      na = 30'(ax >> 1);
      nb = 30'(ay >> 1);
    end else begin
      na = ax[29:0];
      nb = ay[29:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r   <= na;
      ay_r   <= nb;
      zero_a <= (mx == '0);
      yneg_a <= yv[33];
      xneg_a <= xv[33];
    end
  end

  // left normalize so the larger operand lands in [2^29, 2^30)
  logic [29:0] lx, ly, lm;
  always_comb begin
    lx = ax_r;
    ly = ay_r;
    lm = (ax_r > ay_r) ? ax_r : ay_r;
    for (int j = 0; j < 5; j++) begin
      if (lm < (30'(1) << (30 - (16 >> j)))) begin
        lm = lm << (16 >> j);
        lx = lx << (16 >> j);
        ly = ly << (16 >> j);
      end
    end
  end

  opnd_t cx   [0:CORDIC_STEPS];
  opnd_t cy   [0:CORDIC_STEPS];
  ang_t  cz   [0:CORDIC_STEPS];
  logic  zero [0:CORDIC_STEPS];
  logic  yneg [0:CORDIC_STEPS];
  logic  xneg [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0]   <= opnd_t'({4'b0, lx});
      cy[0]   <= opnd_t'({4'b0, ly});
      cz[0]   <= '0;
      zero[0] <= zero_a;
      yneg[0] <= yneg_a;
      xneg[0] <= xneg_a;
    end
  end

  // one rotation per stage
  genvar i;
  generate
    for (i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      always_ff @(posedge clk) begin
        if (en) begin
          if (!cy[i][33]) begin
            cx[i+1] <= cx[i] + (cy[i] >>> i);
            cy[i+1] <= cy[i] - (cx[i] >>> i);
            cz[i+1] <= cz[i] + step_angle(i);
          end else begin
            cx[i+1] <= cx[i] - (cy[i] >>> i);
            cy[i+1] <= cy[i] + (cx[i] >>> i);
            cz[i+1] <= cz[i] - step_angle(i);
          end
          zero[i+1] <= zero[i];
          yneg[i+1] <= yneg[i];
          xneg[i+1] <= xneg[i];
        end
      end
    end
  endgenerate

  // clamp, fold into the half plane, round to 1/128 degree, apply sign
  ang_t               zc, t, tr;
  logic signed [15:0] mag;
  always_comb begin
    zc = cz[CORDIC_STEPS];
    if (zero[CORDIC_STEPS] || zc < 0) begin
      zc = '0;
    end else if (zc > ANG_90) begin
      zc = ANG_90;
    end
    t   = xneg[CORDIC_STEPS] ? (ANG_180 - zc) : zc;
    tr  = (t + 26'sd256) >>> 9;
    mag = tr[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= yneg[CORDIC_STEPS] ? -mag : mag;
    end
  end

endmodule

/* tb/pose_angle_checker.sv */
// checker: predicts euler angles and pass-through fields and compares each output word
`timescale 1ns / 1ps
module pose_angle_checker import q2e_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [31:0] pos_x_in,
  input  logic signed [31:0] pos_y_in,
  input  logic signed [31:0] pos_z_in,
  input  logic               orient_ok_in,
  input  logic               pos_ok_in,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [14:0] pitch_deg,
  input  logic signed [15:0] yaw_deg,
  input  logic signed [15:0] roll_deg,
  input  logic signed [31:0] pos_x_out,
  input  logic signed [31:0] pos_y_out,
  input  logic signed [31:0] pos_z_out,
  input  logic               orient_ok_out,
  input  logic               pos_ok_out,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic signed [15:0] roll;
    logic [31:0]        px;
    logic [31:0]        py;
    logic [31:0]        pz;
    logic               ook;
    logic               pok;
  } pose_word_t;

  localparam longint DEG = 65536;

  pose_word_t expected_poses[$];
  int mismatch_shown;

  // floor shift for signed values
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // first-quadrant vectoring cordic, angle in 2^-16 degree
  function automatic longint first_quad_angle(longint ax, longint ay);
    longint m, x, y, z, xo;
    z = 0;
    m = (ax > ay) ? ax : ay;
    if (m == 0) return 0;
    while (m >= (64'sd1 << 30)) begin
      m >>= 1; ax >>= 1; ay >>= 1;
    end
    while (m < (64'sd1 << 29)) begin
      m <<= 1; ax <<= 1; ay <<= 1;
    end
    x = ax;
    y = ay;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xo = x;
      if (y >= 0) begin
        x += floor_shr(y, i);
        y -= xo >>> i;
        z += longint'(step_angle(i));
      end else begin
        x -= floor_shr(y, i);
        y += xo >>> i;
        z -= longint'(step_angle(i));
      end
    end
    if (z < 0) z = 0;
    if (z > 90 * DEG) z = 90 * DEG;
    return z;
  endfunction

  // atan2 in 1/128 degree
  function automatic longint angle_of(longint yv, longint xv);
    longint t, r;
    t = first_quad_angle(xv < 0 ? -xv : xv, yv < 0 ? -yv : yv);
    if (xv < 0) t = 180 * DEG - t;
    if (t < 0) t = 0;
    if (t > 180 * DEG) t = 180 * DEG;
    r = (t + 256) >>> 9;
    return (yv < 0) ? -r : r;
  endfunction

  function automatic pose_word_t predict_pose();
    pose_word_t p;
    longint w, x, y, z, s, c;
    longint one;
    one = 64'sd1 << 28;
    p = '0;
    if (orient_ok_in) begin
      w = quat_w; x = quat_x; y = quat_y; z = quat_z;
      s = 2 * (w * x - z * y);
      if (s > one) s = one;
      if (s < -one) s = -one;
      c = int_sqrt(longint'((64'd1 << 56) - 64'(s * s)));
      p.pitch = 15'(angle_of(s, c));
      p.yaw   = 16'(angle_of(2 * (w * y + x * z), one - 2 * (x * x + y * y)));
      p.roll  = 16'(angle_of(2 * (w * z + x * y), one - 2 * (x * x + z * z)));
    end
    if (pos_ok_in) begin
      p.px = pos_x_in; p.py = pos_y_in; p.pz = pos_z_in;
    end
    p.ook = orient_ok_in;
    p.pok = pos_ok_in;
    return p;
  endfunction

  assign pending = expected_poses.size();

  // queue expectations on input words, compare on output words
  always @(posedge clk) begin
    pose_word_t got, exp_p;
    if (rst) begin
      fail_count <= 0;
      mismatch_shown = 0;
    end else begin
      if (in_valid && !in_stall) expected_poses.push_back(predict_pose());
      if (out_valid && !out_stall) begin
        got = '{pitch_deg, yaw_deg, roll_deg, pos_x_out, pos_y_out, pos_z_out,
                orient_ok_out, pos_ok_out};
        if (expected_poses.size() == 0) begin
          fail_count <= fail_count + 1;
          if (mismatch_shown < 10) $display("unexpected output word %h", got);
          mismatch_shown++;
        end else begin
          exp_p = expected_poses.pop_front();
          if (got !== exp_p) begin
            fail_count <= fail_count + 1;
            if (mismatch_shown < 10)
              $display("mismatch: exp p=%0d y=%0d r=%0d pos=%h %h %h ok=%b%b got p=%0d y=%0d r=%0d pos=%h %h %h ok=%b%b",
                       exp_p.pitch, exp_p.yaw, exp_p.roll, exp_p.px, exp_p.py, exp_p.pz,
                       exp_p.ook, exp_p.pok, got.pitch, got.yaw, got.roll, got.px,
                       got.py, got.pz, got.ook, got.pok);
            mismatch_shown++;
          end
        end
      end
    end
  end

endmodule

/* tb/quaternion_to_euler_angles_core_test.sv */
// testbench top: pose stimulus, random idling and the final verdict
`timescale 1ns / 1ps
module quaternion_to_euler_angles_core_test;
  import q2e_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic signed [15:0] quat_w = 0, quat_x = 0, quat_y = 0, quat_z = 0;
  logic signed [31:0] pos_x_in = 0, pos_y_in = 0, pos_z_in = 0;
  logic orient_ok_in = 0, pos_ok_in = 0;
  logic signed [14:0] pitch_deg;
  logic signed [15:0] yaw_deg, roll_deg;
  logic signed [31:0] pos_x_out, pos_y_out, pos_z_out;
  logic orient_ok_out, pos_ok_out;
  int fail_count, pending;
  int cycle_count = 0;
  bit calm_phase = 0;

  always #5 clk = ~clk;

  quaternion_to_euler_angles_core dut (.*);
  pose_angle_checker checker_u (.*);

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // random output stall
  always @(negedge clk) out_stall <= calm_phase ? 1'b0 : ($urandom_range(0, 99) < 32);

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      3: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // send one word: hold it until accepted
  task automatic send_pose(logic signed [15:0] w, x, y, z, logic [31:0] px, py, pz,
                           logic ook, logic pok);
    while (!calm_phase && $urandom_range(0, 99) < 32) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
    pos_x_in <= px; pos_y_in <= py; pos_z_in <= pz;
    orient_ok_in <= ook; pos_ok_in <= pok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // unit quaternion from random angles, truncated to Q1.14
  task automatic send_unit_pose();
    real a, b, c, n, w, x, y, z;
    a = $urandom / 4294967296.0 * 6.283; b = $urandom / 4294967296.0 * 6.283;
    c = $urandom / 4294967296.0 * 2.0 - 1.0;
    w = $cos(a) * $sqrt(1.0 - c * c); x = $sin(a) * $sqrt(1.0 - c * c);
    y = c * $cos(b); z = c * $sin(b);
    n = 16384.0;
    send_pose($rtoi(w * n), $rtoi(x * n), $rtoi(y * n), $rtoi(z * n),
              $urandom, $urandom, $urandom, $urandom_range(0, 9) != 0,
              $urandom_range(0, 9) != 0);
  endtask

  initial begin
    int waited;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: identity, axes, extremes, zero operands, folds, invalid flags
    send_pose(16384, 0, 0, 0, 32'h7fffffff, 32'h80000000, 0, 1, 1);
    send_pose(16384, 0, 0, 0, 1, 2, 3, 0, 0);
    send_pose(0, 16384, 0, 0, -1, 0, 0, 1, 1);
    send_pose(0, 0, 16384, 0, 0, 0, 0, 1, 1);
    send_pose(0, 0, 0, 16384, 5, 6, 7, 1, 0);
    send_pose(-16384, 0, 0, 0, 0, 0, 0, 1, 1);
    send_pose(0, 0, 0, 0, 0, 0, 0, 1, 1);
    send_pose(11585, 11585, 0, 0, 0, 0, 0, 1, 1);
    send_pose(11585, -11585, 0, 0, 0, 0, 0, 1, 1);
    send_pose(16384, 16384, 0, 0, 0, 0, 0, 1, 1);
    send_pose(16384, -16384, 16384, 16384, 0, 0, 0, 1, 1);
    send_pose(-16384, -16384, -16384, -16384, 0, 0, 0, 1, 1);
    send_pose(-32768, -32768, 32767, -32768, 0, 0, 0, 1, 1);
    send_pose(32767, 32767, 32767, 32767, 32'hffffffff, 0, 32'h55555555, 1, 1);
    send_pose(0, 11585, 11585, 0, 0, 0, 0, 1, 1);
    send_pose(0, 11585, 0, 11585, 0, 0, 0, 1, 1);
    send_pose(16384, 100, -100, 50, 0, 0, 0, 0, 1);
    // random: mostly unit quaternions, some raw components
    for (int i = 0; i < 1300; i++) begin
      calm_phase = (i >= 500 && i < 650);
      if ($urandom_range(0, 3) != 0) send_unit_pose();
      else send_pose(rand_comp(), rand_comp(), rand_comp(), rand_comp(), $urandom,
                     $urandom, $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
    end
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    waited = 0;
    while (waited < LAT + 20) begin
      @(posedge clk);
      waited++;
    end
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
